/* rtl/core/ars_pkg.sv */
// ----------------------------------------------------------------------------
// ars_pkg
// Shared types and constants of the access range splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package ars_pkg;

    localparam int MAX_DOMAINS = 64;
    localparam int RANK_BITS   = 16;
    localparam int MAX_RESULTS = 64;
    localparam int IDX_W       = $clog2(MAX_DOMAINS);
    localparam int NUM_W       = $clog2(MAX_DOMAINS + 1);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 63;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_OFFSET = 2'd1;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_SPLIT = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OUTSIDE   = 2'd1,
        ST_ZERO_LEN  = 2'd2,
        ST_UNTOUCHED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QRY,
        S_ZERO,
        S_HEAD0,
        S_HEADN,
        S_LOC,
        S_SRCH,
        S_PIECE,
        S_ERR
    } t_state;

    typedef struct packed {
        logic [1:0]           mode;
        logic [IDX_W-1:0]     entry_index;
        logic [62:0]          domain_start;
        logic signed [63:0]   domain_end;
        logic [15:0]          owner_rank;
        logic [62:0]          access_offset;
        logic [61:0]          access_length;
    } t_in_item;

    typedef struct packed {
        logic [15:0]          piece_rank;
        logic [IDX_W-1:0]     piece_domain;
        logic [62:0]          piece_offset;
        logic [61:0]          piece_length;
        logic [62:0]          buffer_position;
        logic                 first_for_domain;
        logic [31:0]          piece_count;
        logic [NUM_W-1:0]     touched_domains;
        logic [1:0]           status;
        logic                 last;
    } t_out_item;

    // domain table word: start, end, rank
    localparam int TBL_W  = 63 + 64 + RANK_BITS;
    // statistics word: count, first position
    localparam int STAT_W = 32 + 63;

endpackage

`default_nettype wire

/* rtl/core/ars_if.sv */
// ----------------------------------------------------------------------------
// ars_if
// Valid/ready channels of the access range splitter.
// ----------------------------------------------------------------------------
`default_nettype none

interface ars_in_if;
    logic               valid;
    logic               ready;
    ars_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ars_out_if;
    logic               valid;
    logic               ready;
    ars_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ars_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ars_pkg::CFG_IDX_W-1:0]     index;
    logic [ars_pkg::CFG_DATA_W-1:0]    wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

/* rtl/core/access_range_splitter.sv */
// ----------------------------------------------------------------------------
// access_range_splitter
// Splits file accesses over a sorted table of file domains.
// ----------------------------------------------------------------------------
// Channels: i_in takes one item per beat (load entry, split access, query
// domain, start new request); o_out gives result beats, the final one of an
// item marked by last; i_cfg writes domain_count and lowest_offset and is
// always ready, to be used only while the block is idle.
// Load and new request give no result. A query reads the table entry and its
// statistics, then forms its result in the result register. A split reads
// the first and last table entries, then for each piece starts the search,
// runs binary search steps (up to about seven for 64 domains), each on one
// table entry read, and forms the piece; the steps run in turn, as the domain
// table memory has a single read port. One item is worked on at a time; i_in
// is ready only when idle.
// Reset sets domain_count to 1, clears lowest_offset, the request flags,
// position, touched count and result valid; domain table undefined until loaded.
// A stalled receiver holds the result register; the block waits for it
// before forming the next piece.
// ----------------------------------------------------------------------------
`default_nettype none

module access_range_splitter (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ars_in_if.sink    i_in,
    ars_out_if.source o_out,
    ars_cfg_if.sink   i_cfg
);

    import ars_pkg::*;

    t_state                r_state, n_state;
    logic                  r_ov;
    t_out_item             r_od;
    logic [NUM_W-1:0]      r_dcount;
    logic [62:0]           r_lowest;
    logic [MAX_DOMAINS-1:0] r_flags;
    logic [62:0]           r_pos;
    logic [NUM_W-1:0]      r_touched;
    logic [63:0]           r_off;
    logic [61:0]           r_rem;
    logic [RES_W-1:0]      r_k;
    logic [NUM_W-1:0]      r_idx, r_lb, r_ub;
    logic                  r_bad0;
    logic [63:0]           r_endlast;
    logic [IDX_W-1:0]      r_qidx;

    // memory ports
    logic                  s_tbl_we, s_stat_we, s_re;
    logic [IDX_W-1:0]      s_raddr;
    logic [TBL_W-1:0]      s_tbl_rd;
    logic [STAT_W-1:0]     s_stat_rd, s_stat_wd;

    logic                  s_in_fire, s_out_free;
    logic [NUM_W-1:0]      s_n;
    logic [62:0]           s_start;
    logic [63:0]           s_end;
    logic [RANK_BITS-1:0]  s_rank;
    logic                  s_flag;
    logic [31:0]           s_cnt;
    logic [62:0]           s_fpos;
    logic                  s_found, s_within, s_loc_bad;
    logic [NUM_W:0]        s_sum;
    logic [NUM_W-1:0]      s_nx;
    logic [63:0]           s_avail;
    logic [61:0]           s_len;
    logic [31:0]           s_cnt_new;
    logic                  s_last;
    logic                  s_piece_fire;

    assign s_in_fire  = i_in.valid && i_in.ready;
    assign s_out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;

    // effective domain count
    always_comb begin
        if (r_dcount == '0) begin
            s_n = NUM_W'(1);
        end else if (r_dcount > NUM_W'(MAX_DOMAINS)) begin
            s_n = NUM_W'(MAX_DOMAINS);
        end else begin
            s_n = r_dcount;
        end
    end

    // memory read words
    assign s_start = s_tbl_rd[TBL_W-1 -: 63];
    assign s_end   = s_tbl_rd[RANK_BITS +: 64];
    assign s_rank  = s_tbl_rd[RANK_BITS-1:0];
    assign s_cnt   = s_stat_rd[STAT_W-1 -: 32];
    assign s_fpos  = s_stat_rd[62:0];
    assign s_flag  = r_flags[r_idx[IDX_W-1:0]];

    // search compare on the entry read last cycle
    assign s_within = !s_end[63] && (r_off <= s_end);
    assign s_found  = ({1'b0, s_start} <= r_off) && s_within;
    assign s_sum    = s_within ? ({1'b0, r_idx} + {1'b0, r_lb})
                               : ({1'b0, r_idx} + {1'b0, r_ub});
    assign s_nx     = s_sum[NUM_W:1];
    assign s_loc_bad = (r_off < {1'b0, r_lowest}) || r_bad0
                       || r_endlast[63] || (r_off > r_endlast);

    // piece length and counters
    assign s_avail   = s_end - r_off + 64'd1;
    assign s_len     = (s_avail < {2'b00, r_rem}) ? s_avail[61:0] : r_rem;
    assign s_cnt_new = !s_flag ? 32'd1
                     : ((s_cnt == 32'hFFFF_FFFF) ? s_cnt : s_cnt + 32'd1);
    assign s_last    = (s_len == r_rem) || (r_k == RES_W'(MAX_RESULTS - 1));
    assign s_piece_fire = (r_state == S_PIECE) && s_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_in_fire) begin
                    case (t_mode'(i_in.data.mode))
                        MODE_QUERY: n_state = S_QRY;
                        MODE_SPLIT: n_state = (i_in.data.access_length == '0)
                                              ? S_ZERO : S_HEAD0;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_QRY, S_ZERO, S_ERR: begin
                if (s_out_free) n_state = S_IDLE;
            end
            S_HEAD0: n_state = S_HEADN;
            S_HEADN: n_state = S_LOC;
            S_LOC:   n_state = s_loc_bad ? S_ERR : S_SRCH;
            S_SRCH: begin
                if (r_idx >= s_n) begin
                    n_state = S_ERR;
                end else if (s_found) begin
                    n_state = S_PIECE;
                end else if (s_nx == r_idx) begin
                    n_state = S_ERR;
                end
            end
            S_PIECE: begin
                if (s_out_free) n_state = s_last ? S_IDLE : S_LOC;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory control
    always_comb begin
        s_tbl_we  = 1'b0;
        s_stat_we = 1'b0;
        s_re      = 1'b0;
        s_raddr   = '0;
        s_stat_wd = {s_cnt_new, (s_flag ? s_fpos : r_pos)};
        case (r_state)
            S_IDLE: begin
                if (s_in_fire && t_mode'(i_in.data.mode) == MODE_LOAD) begin
                    s_tbl_we = 1'b1;
                end
                if (s_in_fire && t_mode'(i_in.data.mode) == MODE_QUERY) begin
                    s_re    = 1'b1;
                    s_raddr = i_in.data.entry_index;
                end
                if (s_in_fire && t_mode'(i_in.data.mode) == MODE_SPLIT) begin
                    s_re    = 1'b1;
                    s_raddr = '0;
                end
            end
            S_HEAD0: begin
                s_re    = 1'b1;
                s_raddr = IDX_W'(s_n - NUM_W'(1));
            end
            S_LOC: begin
                s_re    = 1'b1;
                s_raddr = IDX_W'(s_n >> 1);
            end
            S_SRCH: begin
                if (r_idx < s_n && !s_found && s_nx != r_idx) begin
                    s_re    = 1'b1;
                    s_raddr = s_nx[IDX_W-1:0];
                end
            end
            S_PIECE: begin
                s_stat_we = s_piece_fire;
            end
            default: ;
        endcase
    end

    ars_ram #(.WIDTH(TBL_W), .DEPTH(MAX_DOMAINS)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (s_tbl_we),
        .i_waddr (i_in.data.entry_index),
        .i_wdata ({i_in.data.domain_start, i_in.data.domain_end,
                   i_in.data.owner_rank[RANK_BITS-1:0]}),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_tbl_rd)
    );

    ars_ram #(.WIDTH(STAT_W), .DEPTH(MAX_DOMAINS)) u_stat (
        .i_clk   (i_clk),
        .i_we    (s_stat_we),
        .i_waddr (r_idx[IDX_W-1:0]),
        .i_wdata (s_stat_wd),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_stat_rd)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ov      <= 1'b0;
            r_dcount  <= NUM_W'(1);
            r_lowest  <= '0;
            r_flags   <= '0;
            r_pos     <= '0;
            r_touched <= '0;
        end else begin
            r_state <= n_state;
            // result valid: set when a beat is formed, cleared when taken
            if (((r_state == S_QRY || r_state == S_ZERO || r_state == S_ERR)
                 && s_out_free) || s_piece_fire) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg.valid) begin
                if (i_cfg.index == CFG_DOMAIN_COUNT) r_dcount <= i_cfg.wdata[NUM_W-1:0];
                if (i_cfg.index == CFG_LOWEST_OFFSET) r_lowest <= i_cfg.wdata;
            end
            if (s_in_fire && t_mode'(i_in.data.mode) == MODE_CLEAR) begin
                r_flags   <= '0;
                r_pos     <= '0;
                r_touched <= '0;
            end
            if (s_piece_fire) begin
                r_flags[r_idx[IDX_W-1:0]] <= 1'b1;
                r_pos <= r_pos + {1'b0, s_len};
                if (!s_flag) r_touched <= r_touched + NUM_W'(1);
            end
        end
    end

    // search and result datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_off  <= {1'b0, i_in.data.access_offset};
                r_rem  <= i_in.data.access_length;
                r_k    <= '0;
                r_qidx <= i_in.data.entry_index;
                r_idx  <= {1'b0, i_in.data.entry_index};
            end
            S_HEAD0: r_bad0 <= (s_start < r_lowest);
            S_HEADN: r_endlast <= s_end;
            S_LOC: begin
                r_idx <= s_n >> 1;
                r_lb  <= '0;
                r_ub  <= s_n;
            end
            S_SRCH: begin
                if (!s_found) begin
                    if (s_within) r_ub <= r_idx;
                    else          r_lb <= r_idx;
                    r_idx <= s_nx;
                end
            end
            S_PIECE: begin
                if (s_piece_fire) begin
                    r_off <= r_off + {2'b00, s_len};
                    r_rem <= r_rem - s_len;
                    r_k   <= r_k + RES_W'(1);
                end
            end
            default: ;
        endcase

        if (s_out_free) begin
            case (r_state)
                S_QRY: begin
                    r_od.piece_rank       <= 16'(s_rank);
                    r_od.piece_domain     <= r_qidx;
                    r_od.piece_offset     <= '0;
                    r_od.piece_length     <= '0;
                    r_od.buffer_position  <= s_flag ? s_fpos : '0;
                    r_od.first_for_domain <= 1'b0;
                    r_od.piece_count      <= s_flag ? s_cnt : '0;
                    r_od.touched_domains  <= r_touched;
                    r_od.status           <= s_flag ? ST_OK : ST_UNTOUCHED;
                    r_od.last             <= 1'b1;
                end
                S_ZERO, S_ERR: begin
                    r_od.piece_rank       <= '0;
                    r_od.piece_domain     <= '0;
                    r_od.piece_offset     <= r_off[62:0];
                    r_od.piece_length     <= (r_state == S_ZERO) ? '0 : r_rem;
                    r_od.buffer_position  <= r_pos;
                    r_od.first_for_domain <= 1'b0;
                    r_od.piece_count      <= '0;
                    r_od.touched_domains  <= r_touched;
                    r_od.status           <= (r_state == S_ZERO) ? ST_ZERO_LEN
                                                                 : ST_OUTSIDE;
                    r_od.last             <= 1'b1;
                end
                S_PIECE: begin
                    r_od.piece_rank       <= 16'(s_rank);
                    r_od.piece_domain     <= r_idx[IDX_W-1:0];
                    r_od.piece_offset     <= r_off[62:0];
                    r_od.piece_length     <= s_len;
                    r_od.buffer_position  <= r_pos;
                    r_od.first_for_domain <= !s_flag;
                    r_od.piece_count      <= s_cnt_new;
                    r_od.touched_domains  <= r_touched + NUM_W'(!s_flag);
                    r_od.status           <= ST_OK;
                    r_od.last             <= s_last;
                end
                default: ;
            endcase
        end
    end

    // touched total tracks the first-piece flags
    a_touched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_flags) == 32'(r_touched))
        else $error("touched total disagrees with domain flags");

    // a final piece returns the block to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_piece_fire && s_last) |=> r_state == S_IDLE)
        else $error("block not idle after final piece");

    // no more than the allowed number of pieces per item
    a_piece_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PIECE |-> r_k < RES_W'(MAX_RESULTS))
        else $error("piece limit exceeded");

    // the search index stays inside its bounds
    a_search_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SRCH |-> (r_lb <= r_idx && r_idx <= r_ub))
        else $error("search index out of bounds");

endmodule

`default_nettype wire

/* rtl/core/ars_ram.sv */
// ----------------------------------------------------------------------------
// ars_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ars_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
